// ===== rtl/triangle_normal_and_area_assert.svh =====
// Assertion macros used by the checker file tna_checker.sv
`ifndef TRIANGLE_NORMAL_AND_AREA_ASSERT_SVH
`define TRIANGLE_NORMAL_AND_AREA_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define TNA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define TNA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/tna_pkg.sv =====
`default_nettype none
package tna_pkg;
  localparam int EdgeW  = 17;
  localparam int CrossW = 35;
  localparam int MagW   = 34;
  localparam int SumW   = 70;
  localparam int LenW   = 35;
  localparam int NormW  = 16;
  localparam int AreaW  = 36;
  localparam int QNumW  = MagW + 14;
  localparam int QOne   = 16384;
endpackage
`default_nettype wire

// ===== rtl/triangle_normal_and_area.sv =====
`default_nettype none
// The result is valid after the front stages, the square-root pipeline and the divider pipeline.
// Throughput: one triangle per cycle; every stage holds when the output stalls.
// Depth set by the 35-step square root and 48-step divider pipelines.
// Reset (rst_n low, synchronous) clears all valid bits and holds in_ready low;
// data is not reset.
module triangle_normal_and_area (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [15:0] in_ax,
  input  wire logic signed [15:0] in_ay,
  input  wire logic signed [15:0] in_az,
  input  wire logic signed [15:0] in_bx,
  input  wire logic signed [15:0] in_by_coord,
  input  wire logic signed [15:0] in_bz,
  input  wire logic signed [15:0] in_cx,
  input  wire logic signed [15:0] in_cy,
  input  wire logic signed [15:0] in_cz,
  input  wire logic        in_last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic [35:0]      out_area,
  output logic             out_degenerate,
  output logic             out_last_out
);
  import tna_pkg::*;
  localparam int SqSteps  = LenW;
  localparam int DivSteps = QNumW;
  localparam int Depth    = 5 + SqSteps + DivSteps;

  // Global enable: whole pipe advances when output is free
  logic en;
  logic [Depth-1:0] vld_r;
  assign en       = !out_valid || out_ready;
  assign in_ready = en && rst_n;
  assign out_valid = vld_r[Depth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Depth-2:0], in_valid};
  end

  // Stage 1: edge vectors
  logic signed [EdgeW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic [Depth-1:0] last_r;
  always_ff @(posedge clk) begin
    if (en) begin
      e1x_r <= EdgeW'(in_bx) - EdgeW'(in_ax);
      e1y_r <= EdgeW'(in_by_coord) - EdgeW'(in_ay);
      e1z_r <= EdgeW'(in_bz) - EdgeW'(in_az);
      e2x_r <= EdgeW'(in_cx) - EdgeW'(in_ax);
      e2y_r <= EdgeW'(in_cy) - EdgeW'(in_ay);
      e2z_r <= EdgeW'(in_cz) - EdgeW'(in_az);
      last_r <= {last_r[Depth-2:0], in_last_in};
    end
  end

  // Stage 2: six products
  logic signed [2*EdgeW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= e1y_r * e2z_r;  p1_r <= e1z_r * e2y_r;
      p2_r <= e1z_r * e2x_r;  p3_r <= e1x_r * e2z_r;
      p4_r <= e1x_r * e2y_r;  p5_r <= e1y_r * e2x_r;
    end
  end

  // Stage 3: cross product and magnitudes
  logic signed [CrossW-1:0] nx_r, ny_r, nz_r;
  logic [MagW-1:0] mx_r, my_r, mz_r;
  logic signed [CrossW-1:0] nx_c, ny_c, nz_c;
  always_comb begin
    nx_c = CrossW'(p0_r) - CrossW'(p1_r);
    ny_c = CrossW'(p2_r) - CrossW'(p3_r);
    nz_c = CrossW'(p4_r) - CrossW'(p5_r);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= nx_c; ny_r <= ny_c; nz_r <= nz_c;
      mx_r <= nx_c[CrossW-1] ? MagW'(-nx_c) : MagW'(nx_c);
      my_r <= ny_c[CrossW-1] ? MagW'(-ny_c) : MagW'(ny_c);
      mz_r <= nz_c[CrossW-1] ? MagW'(-nz_c) : MagW'(nz_c);
    end
  end

  // Stage 4: squares
  logic [2*MagW-1:0] sx_r, sy_r, sz_r;
  logic [MagW-1:0] mx4_r, my4_r, mz4_r;
  logic sgx4_r, sgy4_r, sgz4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= mx_r * mx_r; sy_r <= my_r * my_r; sz_r <= mz_r * mz_r;
      mx4_r <= mx_r; my4_r <= my_r; mz4_r <= mz_r;
      sgx4_r <= nx_r[CrossW-1]; sgy4_r <= ny_r[CrossW-1]; sgz4_r <= nz_r[CrossW-1];
    end
  end

  // Stage 5: sum of squares
  logic [SumW-1:0] s_r;
  logic [MagW-1:0] mx5_r, my5_r, mz5_r;
  logic sgx5_r, sgy5_r, sgz5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= SumW'(sx_r) + SumW'(sy_r) + SumW'(sz_r);
      mx5_r <= mx4_r; my5_r <= my4_r; mz5_r <= mz4_r;
      sgx5_r <= sgx4_r; sgy5_r <= sgy4_r; sgz5_r <= sgz4_r;
    end
  end

  // Square-root pipeline, one root bit per stage, magnitudes and signs carried along
  logic [SumW-1:0] rem_r  [SqSteps+1];
  logic [LenW-1:0] root_r [SqSteps+1];
  logic [MagW-1:0] qmx_r [SqSteps+1], qmy_r [SqSteps+1], qmz_r [SqSteps+1];
  logic [2:0]      qsg_r [SqSteps+1];
  always_comb begin
    rem_r[0] = s_r; root_r[0] = '0;
    qmx_r[0] = mx5_r; qmy_r[0] = my5_r; qmz_r[0] = mz5_r;
    qsg_r[0] = {sgx5_r, sgy5_r, sgz5_r};
  end
  for (genvar g = 0; g < SqSteps; g++) begin : g_sq
    logic [SumW-1:0] rem_c;
    logic [LenW-1:0] root_c;
    tna_isqrt_stage #(.BIT(SqSteps - 1 - g)) u_stage (
      .rem_i(rem_r[g]), .root_i(root_r[g]), .rem_o(rem_c), .root_o(root_c)
    );
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1] <= rem_c; root_r[g+1] <= root_c;
        qmx_r[g+1] <= qmx_r[g]; qmy_r[g+1] <= qmy_r[g]; qmz_r[g+1] <= qmz_r[g];
        qsg_r[g+1] <= qsg_r[g];
      end
    end
  end

  // Divider inputs: rounded numerator, guard length zero
  logic [LenW-1:0] len;
  logic [LenW-1:0] den;
  logic [QNumW-1:0] numx, numy, numz;
  assign len = root_r[SqSteps];
  assign den = (len == '0) ? LenW'(1) : len;
  assign numx = {qmx_r[SqSteps], 14'd0} + QNumW'(len >> 1);
  assign numy = {qmy_r[SqSteps], 14'd0} + QNumW'(len >> 1);
  assign numz = {qmz_r[SqSteps], 14'd0} + QNumW'(len >> 1);

  logic [QNumW-1:0] qx, qy, qz;
  tna_divider u_divx (.clk(clk), .en(en), .num_i(numx), .den_i(den), .quo_o(qx));
  tna_divider u_divy (.clk(clk), .en(en), .num_i(numy), .den_i(den), .quo_o(qy));
  tna_divider u_divz (.clk(clk), .en(en), .num_i(numz), .den_i(den), .quo_o(qz));

  // Carry length and signs alongside the dividers
  logic [LenW-1:0] dlen_r [DivSteps+1];
  logic [2:0]      dsg_r  [DivSteps+1];
  always_comb begin
    dlen_r[0] = len; dsg_r[0] = qsg_r[SqSteps];
  end
  for (genvar g = 0; g < DivSteps; g++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dlen_r[g+1] <= dlen_r[g]; dsg_r[g+1] <= dsg_r[g];
      end
    end
  end

  // Output: clamp, sign, zero on degenerate
  function automatic logic [NormW-1:0] fin(input logic [QNumW-1:0] q, input logic sg);
    logic [NormW-1:0] m;
    m = (q > QNumW'(QOne)) ? NormW'(QOne) : q[NormW-1:0];
    return sg ? NormW'(-m) : m;
  endfunction

  logic [LenW-1:0] flen;
  logic degen;
  assign flen  = dlen_r[DivSteps];
  assign degen = (flen == '0);
  assign out_normal_x   = degen ? '0 : fin(qx, dsg_r[DivSteps][2]);
  assign out_normal_y   = degen ? '0 : fin(qy, dsg_r[DivSteps][1]);
  assign out_normal_z   = degen ? '0 : fin(qz, dsg_r[DivSteps][0]);
  assign out_area       = AreaW'(flen >> 1);
  assign out_degenerate = degen;
  assign out_last_out   = last_r[Depth-1];
endmodule
`default_nettype wire

// ===== rtl/tna_isqrt_stage.sv =====
`default_nettype none
// One restoring square-root step: decides one result bit per stage.
module tna_isqrt_stage #(
  parameter int BIT = 0
) (
  input  wire logic [tna_pkg::SumW-1:0] rem_i,
  input  wire logic [tna_pkg::LenW-1:0] root_i,
  output logic      [tna_pkg::SumW-1:0] rem_o,
  output logic      [tna_pkg::LenW-1:0] root_o
);
  import tna_pkg::*;
  logic [SumW+1:0] trial;
  // Compare remainder against (2*root + 2^bit) << bit
  always_comb begin
    trial = ({{(SumW+2-LenW){1'b0}}, root_i} << (BIT + 1))
          + ({{(SumW+1){1'b0}}, 1'b1} << (2 * BIT));
    if ({2'b00, rem_i} >= trial) begin
      rem_o  = rem_i - trial[SumW-1:0];
      root_o = root_i | (LenW'(1) << BIT);
    end else begin
      rem_o  = rem_i;
      root_o = root_i;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tna_divider.sv =====
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, stall-able.
module tna_divider (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [tna_pkg::QNumW-1:0]  num_i,
  input  wire logic [tna_pkg::LenW-1:0]   den_i,
  output logic      [tna_pkg::QNumW-1:0]  quo_o
);
  import tna_pkg::*;
  localparam int Steps = QNumW;
  logic [QNumW-1:0] num_r [Steps+1];
  logic [LenW:0]    rem_r [Steps+1];
  logic [LenW-1:0]  den_r [Steps+1];
  always_comb begin
    num_r[0] = num_i;
    rem_r[0] = '0;
    den_r[0] = den_i;
  end
  // Advance one quotient bit per register stage
  for (genvar g = 0; g < Steps; g++) begin : g_step
    logic [LenW+1:0] sh;
    logic [LenW+1:0] df;
    always_comb begin
      sh = {rem_r[g], num_r[g][QNumW-1]};
      df = sh - {2'b00, den_r[g]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[g+1] <= den_r[g];
        if (!df[LenW+1]) begin
          rem_r[g+1] <= df[LenW:0];
          num_r[g+1] <= {num_r[g][QNumW-2:0], 1'b1};
        end else begin
          rem_r[g+1] <= sh[LenW:0];
          num_r[g+1] <= {num_r[g][QNumW-2:0], 1'b0};
        end
      end
    end
  end
  assign quo_o = num_r[Steps];
endmodule
`default_nettype wire

// ===== rtl/tna_checker.sv =====
`default_nettype none
`include "triangle_normal_and_area_assert.svh"
// Port-level checks on the result channel
module tna_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic signed [15:0] out_normal_x,
  input wire logic [35:0] out_area,
  input wire logic out_degenerate
);
  // Stalled result stays valid
  `TNA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // Degenerate results carry zero area and zero normal x component
  `TNA_ASSERT_IMP(a_degen, clk, rst_n, out_valid && out_degenerate,
    out_area == 36'd0 && out_normal_x == 16'sd0)
  // Input side stalls only behind a stalled output
  `TNA_ASSERT_IMP(a_ready, clk, rst_n, !in_ready, out_valid && !out_ready)
  // Normal x component stays in unit range
  `TNA_ASSERT_IMP(a_range, clk, rst_n, out_valid,
    out_normal_x <= 16'sd16384 && out_normal_x >= -16'sd16384)
endmodule

bind triangle_normal_and_area tna_checker u_tna_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_normal_x(out_normal_x), .out_area(out_area),
  .out_degenerate(out_degenerate)
);
`default_nettype wire
